### src/owtr_pkg.sv
package owtr_pkg;

  localparam int OWTR_SCRATCH_BYTES = 8;

  localparam int US_W   = 10;
  localparam int MS_W   = 12;
  localparam int BIT_W  = 3;
  localparam int BYTE_W = 4;
  localparam int TEMP_W = 7;

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] CMD_SKIP    = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ    = 8'hBE;

  localparam logic [US_W-1:0] IDLE_US       = 10'd80;
  localparam logic [US_W-1:0] RESET_LOW_US  = 10'd640;
  localparam logic [US_W-1:0] PRESENCE_US   = 10'd80;
  localparam logic [US_W-1:0] RECOVERY_US   = 10'd410;
  localparam logic [US_W-1:0] US_PER_MS     = 10'd1000;
  localparam logic [US_W-1:0] SLOT_W_US     = 10'd95;
  localparam logic [US_W-1:0] W_ONE_LOW_US  = 10'd5;
  localparam logic [US_W-1:0] W_ZERO_LOW_US = 10'd90;
  localparam logic [US_W-1:0] SLOT_R_US     = 10'd90;
  localparam logic [US_W-1:0] R_LOW_US      = 10'd2;
  localparam logic [US_W-1:0] R_SAMPLE_US   = 10'd10;

  localparam logic [MS_W-1:0] CONVERT_WAIT_RESET = 12'd1000;

  typedef struct packed {
    logic              crc_fail;
    logic              presence_fail;
    logic [TEMP_W-1:0] temperature;
    logic              temp_valid;
    logic              drive_low;
  } owtr_result_t;

endpackage

### src/owtr_core.sv
module owtr_core
  import owtr_pkg::*;
#(
  parameter int SCRATCH_BYTES = OWTR_SCRATCH_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              us_strobe,
  input  logic              line_level,
  input  logic              cfg_wr_en,
  input  logic [MS_W-1:0]   cfg_wr_data,
  output owtr_result_t      result
);

  typedef enum logic [3:0] {
    PH_IDLE_A  = 4'd0,
    PH_LOW_A   = 4'd1,
    PH_PRES_A  = 4'd2,
    PH_RECOV_A = 4'd3,
    PH_SEND_A  = 4'd4,
    PH_CONV    = 4'd5,
    PH_IDLE_B  = 4'd6,
    PH_LOW_B   = 4'd7,
    PH_PRES_B  = 4'd8,
    PH_RECOV_B = 4'd9,
    PH_SEND_B  = 4'd10,
    PH_READ    = 4'd11
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [US_W-1:0]     us_count_r, us_count_nxt;
  logic [MS_W-1:0]     ms_count_r, ms_count_nxt;
  logic [US_W-1:0]     us_in_ms_r, us_in_ms_nxt;
  logic [BIT_W-1:0]    bit_index_r, bit_index_nxt;
  logic [BYTE_W-1:0]   byte_index_r, byte_index_nxt;
  logic [7:0]          shift_byte_r, shift_byte_nxt;
  logic [7:0]          crc_acc_r, crc_acc_nxt;
  logic [15:0]         raw_r, raw_nxt;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;
  logic [MS_W-1:0]     wait_ms_r;

  logic [US_W-1:0]     us_inc;
  logic [US_W-1:0]     us_in_ms_inc;
  logic [MS_W-1:0]     ms_inc;
  logic [US_W-1:0]     low_len;
  logic                in_scratch;
  logic                valid, pfail, cfail, drive;

  assign us_inc       = us_count_r + 1'b1;
  assign us_in_ms_inc = us_in_ms_r + 1'b1;
  assign ms_inc       = ms_count_r + 1'b1;
  assign in_scratch   = byte_index_r < BYTE_W'(SCRATCH_BYTES);

  always_comb begin
    phase_nxt      = phase_r;
    us_count_nxt   = us_count_r;
    ms_count_nxt   = ms_count_r;
    us_in_ms_nxt   = us_in_ms_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_byte_nxt = shift_byte_r;
    crc_acc_nxt    = crc_acc_r;
    raw_nxt        = raw_r;
    temp_nxt       = temp_r;
    valid          = 1'b0;
    pfail          = 1'b0;
    cfail          = 1'b0;

    unique case (phase_r)
      PH_IDLE_A, PH_IDLE_B: begin
        if (line_level) begin
          phase_nxt    = phase_t'(phase_r + 4'd1);
          us_count_nxt = '0;
        end else if (us_strobe) begin
          if (us_inc >= IDLE_US) begin
            pfail        = 1'b1;
            phase_nxt    = PH_IDLE_A;
            us_count_nxt = '0;
          end else begin
            us_count_nxt = us_inc;
          end
        end
      end
      PH_LOW_A, PH_LOW_B: begin
        if (us_strobe) begin
          if (us_inc >= RESET_LOW_US) begin
            phase_nxt    = phase_t'(phase_r + 4'd1);
            us_count_nxt = '0;
          end else begin
            us_count_nxt = us_inc;
          end
        end
      end
      PH_PRES_A, PH_PRES_B: begin
        if (us_strobe) begin
          us_count_nxt = us_inc;
          if (us_inc >= PRESENCE_US) begin
            us_count_nxt = '0;
            if (!line_level) begin
              phase_nxt = phase_t'(phase_r + 4'd1);
            end else begin
              pfail     = 1'b1;
              phase_nxt = PH_IDLE_A;
            end
          end
        end
      end
      PH_RECOV_A, PH_RECOV_B: begin
        if (us_strobe) begin
          us_count_nxt = us_inc;
          if (us_inc >= RECOVERY_US) begin
            phase_nxt      = phase_t'(phase_r + 4'd1);
            us_count_nxt   = '0;
            shift_byte_nxt = CMD_SKIP;
            bit_index_nxt  = '0;
            byte_index_nxt = '0;
          end
        end
      end
      PH_SEND_A, PH_SEND_B: begin
        if (us_strobe) begin
          us_count_nxt = us_inc;
          if (us_inc >= SLOT_W_US) begin
            us_count_nxt   = '0;
            shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
            bit_index_nxt  = bit_index_r + 1'b1;
            if (bit_index_r == '1) begin
              if (byte_index_r == '0) begin
                byte_index_nxt = BYTE_W'(1);
                shift_byte_nxt = (phase_r == PH_SEND_A) ? CMD_CONVERT : CMD_READ;
              end else if (phase_r == PH_SEND_A) begin
                phase_nxt    = PH_CONV;
                ms_count_nxt = '0;
                us_in_ms_nxt = '0;
              end else begin
                phase_nxt      = PH_READ;
                byte_index_nxt = '0;
                shift_byte_nxt = '0;
                crc_acc_nxt    = '0;
              end
            end
          end
        end
      end
      PH_CONV: begin
        if (us_strobe) begin
          us_in_ms_nxt = us_in_ms_inc;
          if (us_in_ms_inc >= US_PER_MS) begin
            us_in_ms_nxt = '0;
            ms_count_nxt = ms_inc;
            if (ms_inc >= wait_ms_r) begin
              phase_nxt    = PH_IDLE_B;
              us_count_nxt = '0;
            end
          end
        end
      end
      PH_READ: begin
        if (us_strobe) begin
          us_count_nxt = us_inc;
          if (us_inc == R_SAMPLE_US) begin
            shift_byte_nxt = {line_level, shift_byte_r[7:1]};
            if (in_scratch) begin
              crc_acc_nxt = {1'b0, crc_acc_r[7:1]}
                          ^ ((crc_acc_r[0] ^ line_level) ? CRC_POLY : 8'h00);
            end
          end
          if (us_inc >= SLOT_R_US) begin
            us_count_nxt  = '0;
            bit_index_nxt = bit_index_r + 1'b1;
            if (bit_index_r == '1) begin
              if (in_scratch) begin
                if (byte_index_r == BYTE_W'(0)) begin
                  raw_nxt[7:0] = shift_byte_nxt;
                end else if (byte_index_r == BYTE_W'(1)) begin
                  raw_nxt[15:8] = shift_byte_nxt;
                end
                byte_index_nxt = byte_index_r + 1'b1;
              end else begin
                if (shift_byte_nxt == crc_acc_nxt) begin
                  temp_nxt = raw_r[4 +: TEMP_W];
                  valid    = 1'b1;
                end else begin
                  cfail = 1'b1;
                end
                phase_nxt    = PH_IDLE_A;
                us_count_nxt = '0;
              end
            end
          end
        end
      end
      default: begin
        phase_nxt    = PH_IDLE_A;
        us_count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    low_len = shift_byte_nxt[0] ? W_ONE_LOW_US : W_ZERO_LOW_US;
    case (phase_nxt)
      PH_LOW_A, PH_LOW_B:   drive = 1'b1;
      PH_SEND_A, PH_SEND_B: drive = us_count_nxt < low_len;
      PH_READ:              drive = us_count_nxt < R_LOW_US;
      default:              drive = 1'b0;
    endcase
  end

  always_comb begin
    result.drive_low     = drive;
    result.temp_valid    = valid;
    result.temperature   = temp_nxt;
    result.presence_fail = pfail;
    result.crc_fail      = cfail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE_A;
      us_count_r   <= '0;
      ms_count_r   <= '0;
      us_in_ms_r   <= '0;
      bit_index_r  <= '0;
      byte_index_r <= '0;
      shift_byte_r <= '0;
      crc_acc_r    <= '0;
      raw_r        <= '0;
      temp_r       <= '0;
      wait_ms_r    <= CONVERT_WAIT_RESET;
    end else begin
      if (cfg_wr_en) begin
        wait_ms_r <= cfg_wr_data;
      end
      if (step_en) begin
        phase_r      <= phase_nxt;
        us_count_r   <= us_count_nxt;
        ms_count_r   <= ms_count_nxt;
        us_in_ms_r   <= us_in_ms_nxt;
        bit_index_r  <= bit_index_nxt;
        byte_index_r <= byte_index_nxt;
        shift_byte_r <= shift_byte_nxt;
        crc_acc_r    <= crc_acc_nxt;
        raw_r        <= raw_nxt;
        temp_r       <= temp_nxt;
      end
    end
  end

  a_no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(us_count_r) && $stable(temp_r))
    else $error("sensor state changed without an input transfer");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({valid, cfail, pfail}))
    else $error("more than one status pulse in one step");

  a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= BYTE_W'(SCRATCH_BYTES))
    else $error("byte index ran past the check byte");

  a_temp_only_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !valid |=> $stable(temp_r))
    else $error("temperature changed without a good reading");

  a_result_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (valid || cfail) |=> phase_r == PH_IDLE_A)
    else $error("cycle did not restart after the scratchpad read");

endmodule

### src/onewire_temp_sensor_reader.sv
// The result of an input transfer is presented on the output in the cycle after it is taken.
// One input transfer per cycle while the output drains, set by the single-step sensor state update.
// A result waiting in the output register does not stop the next input transfer when it is taken.
// Reset (synchronous, active low) clears the output valid flag and returns the sequencer to the
// idle-line wait before the first bus reset, with the conversion wait set to 1000 ms.
module onewire_temp_sensor_reader
  import owtr_pkg::*;
#(
  parameter int SCRATCH_BYTES = OWTR_SCRATCH_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // us_strobe, line_level
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,   // drive_low, temp_valid, temperature, presence_fail, crc_fail
  input  logic             cfg_wr_en,
  input  logic [MS_W-1:0]  cfg_wr_data
);

  owtr_result_t result;
  logic         accept;
  logic         out_tvalid_r, out_tvalid_nxt;
  logic [15:0]  out_tdata_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  owtr_core #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .us_strobe   (in_tdata[0]),
    .line_level  (in_tdata[1]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (result)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (accept) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {5'b0, result.crc_fail, result.presence_fail, result.temperature,
                      result.temp_valid, result.drive_low};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sim/owtr_checker.sv
`timescale 1ns / 1ps
module owtr_checker
  import owtr_pkg::*;
#(
  parameter int SCRATCH_BYTES = OWTR_SCRATCH_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [15:0]     out_tdata,
  input  logic            cfg_wr_en,
  input  logic [MS_W-1:0] cfg_wr_data,
  output int              fail_count,
  output int              pending
);

  typedef enum logic [4:0] {
    PH_IDLE_A, PH_LOW_A, PH_PRES_A, PH_RECOV_A, PH_SEND_A, PH_CONV,
    PH_IDLE_B, PH_LOW_B, PH_PRES_B, PH_RECOV_B, PH_SEND_B, PH_READ
  } bus_phase_t;

  bus_phase_t          phase;
  logic [MS_W-1:0]     wait_ms;
  logic [US_W-1:0]     us_cnt;
  logic [MS_W-1:0]     ms_cnt;
  logic [US_W-1:0]     us_in_ms;
  logic [BIT_W-1:0]    bit_idx;
  logic [BYTE_W-1:0]   byte_idx;
  logic [7:0]          shreg;
  logic [7:0]          crc;
  logic [15:0]         raw;
  logic [TEMP_W-1:0]   temp;
  owtr_result_t        pin_words[$];
  int                  misses = 0;
  int                  seen = 0;

  function automatic logic us_tick(input logic stb, input logic [US_W-1:0] lim);
    if (!stb) return 1'b0;
    us_cnt = us_cnt + 1'b1;
    return us_cnt >= lim;
  endfunction

  task automatic restart();
    phase = PH_IDLE_A;
    us_cnt = '0;
  endtask

  task automatic advance_bus(input logic stb, input logic line, output owtr_result_t r);
    bus_phase_t ph;
    logic       fb;
    ph = phase;
    r = '0;
    case (ph)
      PH_IDLE_A, PH_IDLE_B: begin
        if (line) begin
          phase = bus_phase_t'(ph + 1'b1);
          us_cnt = '0;
        end else if (us_tick(stb, IDLE_US)) begin
          r.presence_fail = 1'b1;
          restart();
        end
      end
      PH_LOW_A, PH_LOW_B: begin
        if (us_tick(stb, RESET_LOW_US)) begin
          phase = bus_phase_t'(ph + 1'b1);
          us_cnt = '0;
        end
      end
      PH_PRES_A, PH_PRES_B: begin
        if (us_tick(stb, PRESENCE_US)) begin
          if (!line) begin
            phase = bus_phase_t'(ph + 1'b1);
            us_cnt = '0;
          end else begin
            r.presence_fail = 1'b1;
            restart();
          end
        end
      end
      PH_RECOV_A, PH_RECOV_B: begin
        if (us_tick(stb, RECOVERY_US)) begin
          phase = bus_phase_t'(ph + 1'b1);
          us_cnt = '0;
          shreg = CMD_SKIP;
          bit_idx = '0;
          byte_idx = '0;
        end
      end
      PH_SEND_A, PH_SEND_B: begin
        if (us_tick(stb, SLOT_W_US)) begin
          us_cnt = '0;
          shreg = shreg >> 1;
          bit_idx = bit_idx + 1'b1;
          if (bit_idx == '0) begin
            if (byte_idx == '0) begin
              byte_idx = BYTE_W'(1);
              shreg = (ph == PH_SEND_A) ? CMD_CONVERT : CMD_READ;
            end else if (ph == PH_SEND_A) begin
              phase = PH_CONV;
              ms_cnt = '0;
              us_in_ms = '0;
            end else begin
              phase = PH_READ;
              byte_idx = '0;
              shreg = '0;
              crc = '0;
            end
          end
        end
      end
      PH_CONV: begin
        if (stb) begin
          us_in_ms = us_in_ms + 1'b1;
          if (us_in_ms >= US_PER_MS) begin
            us_in_ms = '0;
            ms_cnt = ms_cnt + 1'b1;
            if (ms_cnt >= wait_ms) begin
              phase = PH_IDLE_B;
              us_cnt = '0;
            end
          end
        end
      end
      PH_READ: begin
        if (stb) begin
          us_cnt = us_cnt + 1'b1;
          if (us_cnt == R_SAMPLE_US) begin
            shreg = {line, shreg[7:1]};
            if (byte_idx < SCRATCH_BYTES) begin
              fb = crc[0] ^ line;
              crc = (crc >> 1) ^ (fb ? CRC_POLY : 8'h00);
            end
          end
          if (us_cnt >= SLOT_R_US) begin
            us_cnt = '0;
            bit_idx = bit_idx + 1'b1;
            if (bit_idx == '0) begin
              if (byte_idx < SCRATCH_BYTES) begin
                if (byte_idx == 0) raw[7:0] = shreg;
                else if (byte_idx == 1) raw[15:8] = shreg;
                byte_idx = byte_idx + 1'b1;
              end else begin
                if (shreg == crc) begin
                  temp = raw[10:4];
                  r.temp_valid = 1'b1;
                end else begin
                  r.crc_fail = 1'b1;
                end
                restart();
              end
            end
          end
        end
      end
      default: restart();
    endcase

    case (phase)
      PH_LOW_A, PH_LOW_B: r.drive_low = 1'b1;
      PH_SEND_A, PH_SEND_B: r.drive_low = us_cnt < (shreg[0] ? W_ONE_LOW_US : W_ZERO_LOW_US);
      PH_READ: r.drive_low = us_cnt < R_LOW_US;
      default: r.drive_low = 1'b0;
    endcase
    r.temperature = temp;
  endtask

  task automatic note_miss(input string what, input logic [15:0] want, input logic [15:0] got);
    misses++;
    if (misses <= 10) begin
      $display("%0t: transfer %0d, %s: expected %0h, got %0h", $realtime, seen, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    owtr_result_t want;
    owtr_result_t got;
    if (!rst_n) begin
      wait_ms = CONVERT_WAIT_RESET;
      phase = PH_IDLE_A;
      us_cnt = '0;
      ms_cnt = '0;
      us_in_ms = '0;
      bit_idx = '0;
      byte_idx = '0;
      shreg = '0;
      crc = '0;
      raw = '0;
      temp = '0;
      pin_words.delete();
    end else begin
      if (cfg_wr_en) wait_ms = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got = owtr_result_t'(out_tdata[10:0]);
        seen++;
        if (pin_words.size() == 0) begin
          note_miss("transfer with nothing expected", '0, out_tdata);
        end else begin
          want = pin_words.pop_front();
          if (got.drive_low !== want.drive_low)
            note_miss("drive_low", 16'(want.drive_low), 16'(got.drive_low));
          if (got.temp_valid !== want.temp_valid)
            note_miss("temp_valid", 16'(want.temp_valid), 16'(got.temp_valid));
          if (got.temperature !== want.temperature)
            note_miss("temperature", 16'(want.temperature), 16'(got.temperature));
          if (got.presence_fail !== want.presence_fail)
            note_miss("presence_fail", 16'(want.presence_fail), 16'(got.presence_fail));
          if (got.crc_fail !== want.crc_fail)
            note_miss("crc_fail", 16'(want.crc_fail), 16'(got.crc_fail));
        end
      end
      if (in_tvalid && in_tready) begin
        advance_bus(in_tdata[0], in_tdata[1], want);
        pin_words.push_back(want);
      end
    end
    fail_count <= misses;
    pending <= pin_words.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import owtr_pkg::*;

  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_ANY  = 2;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [7:0]      in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [15:0]     out_tdata;
  logic            cfg_wr_en;
  logic [MS_W-1:0] cfg_wr_data;
  int              fail_count;
  int              pending;

  bit              calm_tx = 1'b0;
  int unsigned     sent = 0;
  logic [MS_W-1:0] wait_ms = CONVERT_WAIT_RESET;

  onewire_temp_sensor_reader uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  owtr_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_item(input logic stb, input logic line);
    int unsigned gap;
    gap = calm_tx ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, line, stb};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (sent % 256 == 0) calm_tx = ($urandom_range(0, 3) == 0);
  endtask

  // Offers items until n microsecond strobes have been transferred.
  task automatic run_us(input int unsigned n, input int mode);
    int unsigned done;
    logic        stb;
    logic        lv;
    done = 0;
    while (done < n) begin
      stb = calm_tx || ($urandom_range(0, 7) != 0);
      lv = (mode == LINE_ANY) ? logic'($urandom_range(0, 1)) : logic'(mode == LINE_HIGH);
      push_item(stb, lv);
      if (stb) done++;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_wait(input logic [MS_W-1:0] ms);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wait_ms = ms;
  endtask

  // Idle-line wait, reset pulse, presence sample and, if present, recovery, from a cleared microsecond count.
  task automatic bus_reset(input bit present);
    run_us($urandom_range(0, int'(IDLE_US) - 1), LINE_LOW);
    push_item(logic'($urandom_range(0, 1)), 1'b1);
    run_us(int'(RESET_LOW_US), LINE_ANY);
    run_us(PRESENCE_US - 1, LINE_ANY);
    push_item(1'b1, !present);
    if (present) run_us(int'(RECOVERY_US), LINE_ANY);
  endtask

  task automatic read_scratchpad(input bit good);
    logic [7:0]  pad [0:OWTR_SCRATCH_BYTES];
    logic [7:0]  sum;
    logic        fb;
    int unsigned k;
    int unsigned b;
    for (k = 0; k < OWTR_SCRATCH_BYTES; k++) pad[k] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: begin
        pad[0] = 8'hFF;
        pad[1] = 8'h07;
      end
      1: begin
        pad[0] = 8'h00;
        pad[1] = 8'h00;
      end
      default: ;
    endcase
    sum = 8'h00;
    for (k = 0; k < OWTR_SCRATCH_BYTES; k++) begin
      for (b = 0; b < 8; b++) begin
        fb = sum[0] ^ pad[k][b];
        sum = (sum >> 1) ^ (fb ? CRC_POLY : 8'h00);
      end
    end
    pad[OWTR_SCRATCH_BYTES] = good ? sum : sum ^ (8'h01 << $urandom_range(0, 7));
    for (k = 0; k <= OWTR_SCRATCH_BYTES; k++) begin
      for (b = 0; b < 8; b++) begin
        run_us(R_SAMPLE_US - 1, LINE_ANY);
        push_item(1'b1, pad[k][b]);
        run_us(int'(SLOT_R_US - R_SAMPLE_US), LINE_ANY);
      end
    end
  endtask

  task automatic measure(input bit good);
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    run_us(((wait_ms == 0) ? 1 : wait_ms) * US_PER_MS, LINE_ANY);
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    read_scratchpad(good);
  endtask

  // The receiver holds off for long stretches at two points while the sender keeps offering.
  initial begin
    int unsigned taken;
    int unsigned stall;
    bit          calm_rx;
    taken = 0;
    calm_rx = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 3);
      if (taken == 200 || taken == 60000) stall = 64;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (taken % 256 == 0) calm_rx = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A high line without a strobe starts the reset pulse, then the presence sample sees no sensor.
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    run_us(int'(RESET_LOW_US), LINE_ANY);
    run_us(PRESENCE_US - 1, LINE_ANY);
    push_item(1'b1, 1'b1);
    // The line never idles high.
    run_us(int'(IDLE_US), LINE_LOW);

    set_wait(12'd0);
    measure(1'b1);
    set_wait(12'd1);
    measure(1'b0);

    // Presence failure and idle timeout on the second reset.
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    run_us(int'(US_PER_MS), LINE_ANY);
    bus_reset(1'b0);
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    run_us(int'(US_PER_MS), LINE_ANY);
    run_us(int'(IDLE_US), LINE_LOW);

    // The wait is shortened while the conversion is in progress.
    set_wait(12'd3);
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    run_us(1500, LINE_ANY);
    set_wait(12'd1);
    run_us(500, LINE_ANY);
    bus_reset(1'b1);
    run_us(16 * SLOT_W_US, LINE_ANY);
    read_scratchpad(1'b1);

    repeat (4) begin
      set_wait(12'($urandom_range(1, 2)));
      measure($urandom_range(0, 3) != 0);
    end

    set_wait(12'd4095);
    repeat (400) push_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));

    in_tvalid <= 1'b0;
    k = 0;
    do begin
      @(posedge clk);
      k++;
    end while (pending != 0 && k < 2000);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
